/* rtl/cgs_pkg.sv */
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared constants, point type, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int CW   = 16;
  localparam int MAXP = 64;
  localparam int AW   = $clog2(MAXP);
  localparam int NW   = $clog2(MAXP + 1);
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = DW + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef enum logic [5:0] {
    S_LOAD, S_PIV_INIT, S_PIV_RD, S_PIV_CMP, S_SW_RD, S_SW_A, S_SW_B,
    S_SR_RD, S_SR_T, S_IL_RD, S_IL_Q, S_IL_MUL, S_IL_CMP, S_IL_DEC, S_PLACE,
    S_RD_INIT, S_R_RD, S_R_A, S_R_RDB, S_R_B, S_R_MUL, S_R_CMP, S_R_ADV, S_R_WR,
    S_CHK, S_ST0, S_ST1, S_ST2, S_TOP, S_RD1, S_S_O, S_S_A, S_S_B, S_S_MUL,
    S_S_CMP, S_POP, S_PUSH, S_E_RD, S_E_PT, S_E_OUT, S_NH, S_FIN
  } state_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_PIV_INIT, OP_PIV_RD, OP_PIV_CMP, OP_SW_RD, OP_SW_A,
    OP_SW_B, OP_SR_RD, OP_SR_T, OP_IL_RD, OP_IL_Q, OP_MUL, OP_IL_DEC, OP_PLACE,
    OP_RD_INIT, OP_R_RD, OP_R_A, OP_R_RDB, OP_R_B, OP_R_ADV, OP_R_WR,
    OP_ST0, OP_ST1, OP_ST2, OP_S_RD0, OP_S_RD1, OP_S_O, OP_S_A, OP_S_B,
    OP_S_POP, OP_PUSH, OP_E_RD, OP_E_PT, OP_E_OUT, OP_NH, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic i1_lt_n;
    logic n_gt2;
    logic j_gt1;
    logic goes_first;
    logic c_zero;
    logic c_le0;
    logic i_lt_n;
    logic m_lt3;
    logic i_lt_m;
    logic d_ge2;
    logic d_eq1;
    logic out_free;
  } status_t;

endpackage

/* rtl/cgs_pt_if.sv */
// ----------------------------------------------------------------------------
// cgs_pt_if
// Input point channel: valid/ready with one point word.
// ----------------------------------------------------------------------------
interface cgs_pt_if;
  logic                           valid;
  logic                           ready;
  logic signed [cgs_pkg::CW-1:0]  px;
  logic signed [cgs_pkg::CW-1:0]  py;
  logic                           last_point;

  modport source (output valid, px, py, last_point, input ready);
  modport sink   (input valid, px, py, last_point, output ready);
endinterface

/* rtl/cgs_hull_if.sv */
// ----------------------------------------------------------------------------
// cgs_hull_if
// Output hull channel: valid/ready with one vertex word.
// ----------------------------------------------------------------------------
interface cgs_hull_if;
  logic                           valid;
  logic                           ready;
  logic signed [cgs_pkg::CW-1:0]  hull_x;
  logic signed [cgs_pkg::CW-1:0]  hull_y;
  logic                           last_vertex;
  logic                           no_hull;
  logic                           points_dropped;

  modport source (output valid, hull_x, hull_y, last_vertex, no_hull, points_dropped,
                  input ready);
  modport sink   (input valid, hull_x, hull_y, last_vertex, no_hull, points_dropped,
                  output ready);
endinterface

/* rtl/cgs_ctrl.sv */
// ----------------------------------------------------------------------------
// cgs_ctrl
// Sequencer for load, pivot search, insertion sort, angle reduction, scan, emit.
// ----------------------------------------------------------------------------
module cgs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  cgs_pkg::status_t st,
  output cgs_pkg::cmd_t    cmd
);
  import cgs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (st.in_fire && st.in_last) state_next = S_PIV_INIT;
      S_PIV_INIT: state_next = S_PIV_RD;
      S_PIV_RD:   state_next = S_PIV_CMP;
      S_PIV_CMP:  state_next = st.i1_lt_n ? S_PIV_RD : S_SW_RD;
      S_SW_RD:    state_next = S_SW_A;
      S_SW_A:     state_next = S_SW_B;
      S_SW_B:     state_next = st.n_gt2 ? S_SR_RD : S_RD_INIT;
      S_SR_RD:    state_next = S_SR_T;
      S_SR_T:     state_next = S_IL_RD;
      S_IL_RD:    state_next = st.j_gt1 ? S_IL_Q : S_PLACE;
      S_IL_Q:     state_next = S_IL_MUL;
      S_IL_MUL:   state_next = S_IL_CMP;
      S_IL_CMP:   state_next = st.goes_first ? S_IL_DEC : S_PLACE;
      S_IL_DEC:   state_next = S_IL_RD;
      S_PLACE:    state_next = st.i1_lt_n ? S_SR_RD : S_RD_INIT;
      S_RD_INIT:  state_next = S_R_RD;
      S_R_RD:     state_next = st.i_lt_n ? S_R_A : S_CHK;
      S_R_A:      state_next = S_R_RDB;
      S_R_RDB:    state_next = st.i1_lt_n ? S_R_B : S_R_WR;
      S_R_B:      state_next = S_R_MUL;
      S_R_MUL:    state_next = S_R_CMP;
      S_R_CMP:    state_next = st.c_zero ? S_R_ADV : S_R_WR;
      S_R_ADV:    state_next = S_R_RDB;
      S_R_WR:     state_next = S_R_RD;
      S_CHK:      state_next = st.m_lt3 ? S_NH : S_ST0;
      S_ST0:      state_next = S_ST1;
      S_ST1:      state_next = S_ST2;
      S_ST2:      state_next = S_TOP;
      S_TOP: begin
        if (!st.i_lt_m)      state_next = S_E_RD;
        else if (!st.d_ge2)  state_next = S_PUSH;
        else                 state_next = S_RD1;
      end
      S_RD1:      state_next = S_S_O;
      S_S_O:      state_next = S_S_A;
      S_S_A:      state_next = S_S_B;
      S_S_B:      state_next = S_S_MUL;
      S_S_MUL:    state_next = S_S_CMP;
      S_S_CMP:    state_next = st.c_le0 ? S_POP : S_PUSH;
      S_POP:      state_next = S_TOP;
      S_PUSH:     state_next = S_TOP;
      S_E_RD:     state_next = S_E_PT;
      S_E_PT:     state_next = S_E_OUT;
      S_E_OUT:    if (st.out_free) state_next = st.d_eq1 ? S_FIN : S_E_RD;
      S_NH:       if (st.out_free) state_next = S_FIN;
      S_FIN:      state_next = S_LOAD;
      default:    state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd.op = OP_NOP;
    unique case (state)
      S_LOAD:     cmd.op = OP_LOAD;
      S_PIV_INIT: cmd.op = OP_PIV_INIT;
      S_PIV_RD:   cmd.op = OP_PIV_RD;
      S_PIV_CMP:  cmd.op = OP_PIV_CMP;
      S_SW_RD:    cmd.op = OP_SW_RD;
      S_SW_A:     cmd.op = OP_SW_A;
      S_SW_B:     cmd.op = OP_SW_B;
      S_SR_RD:    cmd.op = OP_SR_RD;
      S_SR_T:     cmd.op = OP_SR_T;
      S_IL_RD:    cmd.op = OP_IL_RD;
      S_IL_Q:     cmd.op = OP_IL_Q;
      S_IL_MUL:   cmd.op = OP_MUL;
      S_IL_CMP:   cmd.op = OP_NOP;
      S_IL_DEC:   cmd.op = OP_IL_DEC;
      S_PLACE:    cmd.op = OP_PLACE;
      S_RD_INIT:  cmd.op = OP_RD_INIT;
      S_R_RD:     cmd.op = OP_R_RD;
      S_R_A:      cmd.op = OP_R_A;
      S_R_RDB:    cmd.op = OP_R_RDB;
      S_R_B:      cmd.op = OP_R_B;
      S_R_MUL:    cmd.op = OP_MUL;
      S_R_CMP:    cmd.op = OP_NOP;
      S_R_ADV:    cmd.op = OP_R_ADV;
      S_R_WR:     cmd.op = OP_R_WR;
      S_CHK:      cmd.op = OP_NOP;
      S_ST0:      cmd.op = OP_ST0;
      S_ST1:      cmd.op = OP_ST1;
      S_ST2:      cmd.op = OP_ST2;
      S_TOP:      cmd.op = OP_S_RD0;
      S_RD1:      cmd.op = OP_S_RD1;
      S_S_O:      cmd.op = OP_S_O;
      S_S_A:      cmd.op = OP_S_A;
      S_S_B:      cmd.op = OP_S_B;
      S_S_MUL:    cmd.op = OP_MUL;
      S_S_CMP:    cmd.op = OP_NOP;
      S_POP:      cmd.op = OP_S_POP;
      S_PUSH:     cmd.op = OP_PUSH;
      S_E_RD:     cmd.op = OP_E_RD;
      S_E_PT:     cmd.op = OP_E_PT;
      S_E_OUT:    cmd.op = OP_E_OUT;
      S_NH:       cmd.op = OP_NH;
      S_FIN:      cmd.op = OP_FIN;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

/* rtl/cgs_dp.sv */
// ----------------------------------------------------------------------------
// cgs_dp
// Point store, hull stack, counters, cross product unit and output register.
// ----------------------------------------------------------------------------
module cgs_dp (
  input  logic             clk,
  input  logic             rst,
  input  cgs_pkg::cmd_t    cmd,
  output cgs_pkg::status_t st,
  cgs_pt_if.sink           pts,
  cgs_hull_if.source       hull
);
  import cgs_pkg::*;

  pt_t              pmem [MAXP];
  logic [AW-1:0]    smem [MAXP];

  pt_t              prd;
  logic [AW-1:0]    srd;

  logic [NW-1:0]    cnt, n, i, j, m, d;
  logic             ovf;
  logic [AW-1:0]    best;
  pt_t              bpt, piv, ro, ra, rb;

  logic signed [PW-1:0] p1, p2;
  logic                 a_near;

  logic             ov, lv, nh, pd;
  logic signed [CW-1:0] hx, hy;

  logic             pw_en, pr_en, sw_en, sr_en;
  logic [AW-1:0]    pw_addr, pr_addr, sw_addr, sr_addr;
  pt_t              pw_data, in_pt;
  logic [AW-1:0]    sw_data;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic [DW-1:0]        aax, aay, abx, aby;
  logic [LW-1:0]        l1a, l1b;
  logic signed [PW:0]   cr;
  logic                 less, c_pos;
  logic [NW-1:0]        i1, dm1, dm2;

  assign in_pt.x = pts.px;
  assign in_pt.y = pts.py;
  assign i1  = i + NW'(1);
  assign dm1 = d - NW'(1);
  assign dm2 = d - NW'(2);

  // cross product about ro, squared-distance order via L1 on a common ray
  assign dax = DW'(ra.x) - DW'(ro.x);
  assign day = DW'(ra.y) - DW'(ro.y);
  assign dbx = DW'(rb.x) - DW'(ro.x);
  assign dby = DW'(rb.y) - DW'(ro.y);
  assign aax = dax[DW-1] ? DW'(-dax) : DW'(dax);
  assign aay = day[DW-1] ? DW'(-day) : DW'(day);
  assign abx = dbx[DW-1] ? DW'(-dbx) : DW'(dbx);
  assign aby = dby[DW-1] ? DW'(-dby) : DW'(dby);
  assign l1a = LW'(aax) + LW'(aay);
  assign l1b = LW'(abx) + LW'(aby);
  assign cr    = (PW+1)'(p1) - (PW+1)'(p2);
  assign c_pos = !cr[PW] && (cr != '0);

  assign less = (prd.y < bpt.y) || ((prd.y == bpt.y) && (prd.x < bpt.x));

  assign pts.ready = (cmd.op == OP_LOAD);

  assign hull.valid          = ov;
  assign hull.hull_x         = hx;
  assign hull.hull_y         = hy;
  assign hull.last_vertex    = lv;
  assign hull.no_hull        = nh;
  assign hull.points_dropped = pd;

  always_comb begin
    st.in_fire    = pts.valid && pts.ready;
    st.in_last    = pts.last_point;
    st.i1_lt_n    = i1 < n;
    st.n_gt2      = n > NW'(2);
    st.j_gt1      = j > NW'(1);
    st.goes_first = c_pos || ((cr == '0) && a_near);
    st.c_zero     = (cr == '0);
    st.c_le0      = !c_pos;
    st.i_lt_n     = i < n;
    st.m_lt3      = m < NW'(3);
    st.i_lt_m     = i < m;
    st.d_ge2      = d >= NW'(2);
    st.d_eq1      = d == NW'(1);
    st.out_free   = !ov || hull.ready;
  end

  always_comb begin
    pw_en   = 1'b0;
    pw_addr = i[AW-1:0];
    pw_data = ra;
    pr_en   = 1'b0;
    pr_addr = i[AW-1:0];
    sw_en   = 1'b0;
    sw_addr = d[AW-1:0];
    sw_data = i[AW-1:0];
    sr_en   = 1'b0;
    sr_addr = dm1[AW-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        pw_en   = pts.valid && (cnt < NW'(MAXP));
        pw_addr = cnt[AW-1:0];
        pw_data = in_pt;
      end
      OP_PIV_RD, OP_SR_RD, OP_R_RD, OP_S_A: pr_en = 1'b1;
      OP_SW_RD: begin
        pr_en   = 1'b1;
        pr_addr = '0;
      end
      OP_SW_A: begin
        pw_en   = 1'b1;
        pw_addr = '0;
        pw_data = bpt;
      end
      OP_SW_B: begin
        pw_en   = 1'b1;
        pw_addr = best;
        pw_data = rb;
      end
      OP_IL_RD: begin
        pr_en   = 1'b1;
        pr_addr = AW'(j - NW'(1));
      end
      OP_IL_DEC: begin
        pw_en   = 1'b1;
        pw_addr = j[AW-1:0];
        pw_data = rb;
      end
      OP_PLACE: begin
        pw_en   = 1'b1;
        pw_addr = j[AW-1:0];
        pw_data = ra;
      end
      OP_R_RDB: begin
        pr_en   = 1'b1;
        pr_addr = i1[AW-1:0];
      end
      OP_R_WR: begin
        pw_en   = 1'b1;
        pw_addr = m[AW-1:0];
        pw_data = ra;
      end
      OP_ST0: begin
        sw_en   = 1'b1;
        sw_addr = AW'(0);
        sw_data = AW'(0);
      end
      OP_ST1: begin
        sw_en   = 1'b1;
        sw_addr = AW'(1);
        sw_data = AW'(1);
      end
      OP_ST2: begin
        sw_en   = 1'b1;
        sw_addr = AW'(2);
        sw_data = AW'(2);
      end
      OP_S_RD0: begin
        sr_en   = 1'b1;
        sr_addr = dm2[AW-1:0];
      end
      OP_S_RD1: begin
        pr_en   = 1'b1;
        pr_addr = srd;
        sr_en   = 1'b1;
      end
      OP_S_O, OP_E_PT: begin
        pr_en   = 1'b1;
        pr_addr = srd;
      end
      OP_PUSH: sw_en = 1'b1;
      OP_E_RD: sr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    if (pr_en) prd <= pmem[pr_addr];
    if (sw_en) smem[sw_addr] <= sw_data;
    if (sr_en) srd <= smem[sr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
      d   <= '0;
      ov  <= 1'b0;
      piv <= '0;
    end else begin
      if (ov && hull.ready && (cmd.op != OP_E_OUT) && (cmd.op != OP_NH)) ov <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          if (pts.valid) begin
            if (cnt < NW'(MAXP)) cnt <= cnt + NW'(1);
            else                 ovf <= 1'b1;
          end
        end
        OP_PIV_INIT: begin
          n <= cnt;
          i <= '0;
        end
        OP_PIV_CMP: begin
          if ((i == '0) || less) begin
            best <= i[AW-1:0];
            bpt  <= prd;
          end
          i <= i1;
        end
        OP_SW_A: begin
          rb  <= prd;
          piv <= bpt;
          ro  <= bpt;
        end
        OP_SW_B: i <= NW'(2);
        OP_SR_T: begin
          ra <= prd;
          j  <= i;
        end
        OP_IL_Q, OP_R_B, OP_S_B: rb <= prd;
        OP_MUL: begin
          p1     <= dax * dby;
          p2     <= day * dbx;
          a_near <= l1a < l1b;
        end
        OP_IL_DEC: j <= j - NW'(1);
        OP_PLACE:  i <= i1;
        OP_RD_INIT: begin
          m  <= NW'(1);
          i  <= NW'(1);
          ro <= piv;
        end
        OP_R_A, OP_S_A: ra <= prd;
        OP_R_ADV: begin
          ra <= rb;
          i  <= i1;
        end
        OP_R_WR: begin
          m <= m + NW'(1);
          i <= i1;
        end
        OP_ST2: begin
          d <= NW'(3);
          i <= NW'(3);
        end
        OP_S_O:   ro <= prd;
        OP_S_POP: d  <= dm1;
        OP_PUSH: begin
          d <= d + NW'(1);
          i <= i1;
        end
        OP_E_OUT: begin
          if (!ov || hull.ready) begin
            ov <= 1'b1;
            hx <= prd.x;
            hy <= prd.y;
            lv <= (d == NW'(1));
            nh <= 1'b0;
            pd <= ovf;
            d  <= dm1;
          end
        end
        OP_NH: begin
          if (!ov || hull.ready) begin
            ov <= 1'b1;
            hx <= '0;
            hy <= '0;
            lv <= 1'b1;
            nh <= 1'b1;
            pd <= ovf;
          end
        end
        OP_FIN: begin
          cnt <= '0;
          ovf <= 1'b0;
          d   <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/convex_hull_graham_scan.sv */
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Graham scan convex hull over a set of up to 64 signed 16-bit points.
// Loading takes one point word per cycle while valid. After the last point the
// one sequencer runs pivot search, insertion sort, angle reduction, the stack
// scan and the emit of vertices, in that order, over one read and one write
// port per store.
// Reset clears cnt, ovf, d, ov, piv and state; point/stack stores hold junk.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan (
  input  logic        clk,
  input  logic        rst,
  cgs_pt_if.sink      pts,
  cgs_hull_if.source  hull
);
  import cgs_pkg::*;

  cmd_t    cmd;
  status_t st;

  cgs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  cgs_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .st   (st),
    .pts  (pts),
    .hull (hull)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds point sets to convex_hull_graham_scan with bursty input and a stalling
// output, predicts the hull of each set and checks every vertex word in order.
// ----------------------------------------------------------------------------
module testbench;

  import cgs_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 lastv;
    logic                 none;
    logic                 dropped;
  } vertex_t;

  class hull_scoreboard;
    longint  xs[MAXP];
    longint  ys[MAXP];
    int      cnt;
    bit      ovf;
    longint  pvx, pvy;
    int      stk[MAXP];
    vertex_t exp_q[$];
    int      errors;

    function new();
      cnt = 0;
      ovf = 0;
      errors = 0;
    endfunction

    function longint cross_prod(longint ox, longint oy, longint ax, longint ay,
                                longint bx, longint by);
      return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
    endfunction

    function bit ahead(longint ax, longint ay, longint bx, longint by);
      longint c;
      c = cross_prod(pvx, pvy, ax, ay, bx, by);
      if (c > 0) return 1;
      if (c < 0) return 0;
      return ((ax - pvx) ** 2 + (ay - pvy) ** 2) < ((bx - pvx) ** 2 + (by - pvy) ** 2);
    endfunction

    function void push_vertex(longint x, longint y, bit lastv, bit none);
      vertex_t v;
      v.x = x[CW-1:0];
      v.y = y[CW-1:0];
      v.lastv = lastv;
      v.none = none;
      v.dropped = ovf;
      exp_q = {exp_q, v};
    endfunction

    function void build_hull();
      int n, best, i, j, m, d;
      longint tx, ty;
      n = cnt;
      best = 0;
      for (i = 1; i < n; i++)
        if (ys[i] < ys[best] || (ys[i] == ys[best] && xs[i] < xs[best])) best = i;
      tx = xs[0]; ty = ys[0];
      xs[0] = xs[best]; ys[0] = ys[best];
      xs[best] = tx; ys[best] = ty;
      pvx = xs[0]; pvy = ys[0];
      for (i = 2; i < n; i++) begin
        tx = xs[i]; ty = ys[i];
        j = i;
        while (j > 1 && ahead(tx, ty, xs[j-1], ys[j-1])) begin
          xs[j] = xs[j-1]; ys[j] = ys[j-1];
          j--;
        end
        xs[j] = tx; ys[j] = ty;
      end
      m = 1;
      for (i = 1; i < n; i++) begin
        while (i + 1 < n && cross_prod(pvx, pvy, xs[i], ys[i], xs[i+1], ys[i+1]) == 0) i++;
        xs[m] = xs[i]; ys[m] = ys[i];
        m++;
      end
      if (m < 3) begin
        push_vertex(0, 0, 1, 1);
      end else begin
        stk[0] = 0; stk[1] = 1; stk[2] = 2;
        d = 3;
        for (i = 3; i < m; i++) begin
          while (d >= 2 && cross_prod(xs[stk[d-2]], ys[stk[d-2]], xs[stk[d-1]],
                                      ys[stk[d-1]], xs[i], ys[i]) <= 0)
            d--;
          if (d < MAXP) begin
            stk[d] = i;
            d++;
          end
        end
        while (d > 0) begin
          d--;
          push_vertex(xs[stk[d]], ys[stk[d]], d == 0, 0);
        end
      end
      cnt = 0;
      ovf = 0;
    endfunction

    function void note(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lastp);
      if (cnt < MAXP) begin
        xs[cnt] = x;
        ys[cnt] = y;
        cnt++;
      end else begin
        ovf = 1;
      end
      if (lastp) build_hull();
    endfunction

    function void check(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                        logic lastv, logic none, logic dropped);
      vertex_t e;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word x=%0d y=%0d", x, y);
        return;
      end
      e = exp_q.pop_front();
      if ((none !== e.none) || (lastv !== e.lastv) || (dropped !== e.dropped) ||
          (x !== e.x) || (y !== e.y)) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch exp x=%0d y=%0d lv=%0b nh=%0b pd=%0b",
                    " got x=%0d y=%0d lv=%0b nh=%0b pd=%0b"},
                   e.x, e.y, e.lastv, e.none, e.dropped, x, y, lastv, none, dropped);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  cgs_pt_if   pts();
  cgs_hull_if hull();

  convex_hull_graham_scan u_top (.clk(clk), .rst(rst), .pts(pts), .hull(hull));

  hull_scoreboard sb;
  int burst_left;
  int cycles;
  int rcv_phase;
  bit rcv_stall;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: windows of free flow or random stalls, each chosen at random
  always @(posedge clk) begin
    if (rst) begin
      hull.ready <= 1'b0;
      rcv_phase <= 0;
      rcv_stall <= 0;
    end else begin
      if (hull.valid && hull.ready)
        sb.check(hull.hull_x, hull.hull_y, hull.last_vertex, hull.no_hull,
                 hull.points_dropped);
      if (rcv_phase == 0) begin
        rcv_phase <= $urandom_range(20, 300);
        rcv_stall <= $urandom_range(0, 1);
      end else begin
        rcv_phase <= rcv_phase - 1;
      end
      hull.ready <= rcv_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lastp);
    int gap;
    pts.valid <= 1'b1;
    pts.px <= x;
    pts.py <= y;
    pts.last_point <= lastp;
    do @(posedge clk); while (!pts.ready);
    sb.note(x, y, lastp);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 2))
          0: return CW'(-32768);
          1: return CW'(32767);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int size, int mode);
    for (int i = 0; i < size; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == size - 1);
  endtask

  initial begin
    int sent;
    int size;
    bit big_done;
    bit paused;
    sb = new();
    burst_left = 0;
    rst <= 1'b1;
    pts.valid <= 1'b0;
    pts.px <= '0;
    pts.py <= '0;
    pts.last_point <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single point, two points, collinear triple, identical points
    send_point(5, 5, 1);
    send_point(-3, 7, 0);
    send_point(9, -1, 1);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(2, 2, 1);
    send_point(4, 4, 0);
    send_point(4, 4, 0);
    send_point(4, 4, 1);
    // extreme corners with pivot duplicate, interior point and collinear edge point
    send_point(32767, 32767, 0);
    send_point(-32768, -32768, 0);
    send_point(32767, -32768, 0);
    send_point(-32768, -32768, 0);
    send_point(0, 0, 0);
    send_point(0, -32768, 0);
    send_point(-32768, 32767, 1);
    // square with points on two of its sides
    send_point(-1, -1, 0);
    send_point(1, -1, 0);
    send_point(1, 1, 0);
    send_point(-1, 1, 0);
    send_point(0, 1, 0);
    send_point(-1, 0, 1);

    sent = 0;
    big_done = 0;
    paused = 0;
    while (sent < 108) begin
      if (sent >= 40 && !big_done) begin
        // full store plus overflow
        send_set(MAXP + 3, 0);
        sent += MAXP + 3;
        big_done = 1;
      end else begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        send_set(size, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
        sent += size;
      end
      if (sent > 90 && !paused) begin
        paused = 1;
        pts.valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge clk);
      end
    end
    pts.valid <= 1'b0;

    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* convex_hull_graham_scan.f */
rtl/cgs_pkg.sv
rtl/cgs_pt_if.sv
rtl/cgs_hull_if.sv
rtl/cgs_ctrl.sv
rtl/cgs_dp.sv
rtl/convex_hull_graham_scan.sv
sim/testbench.sv
